FILE: hdl/assert_macros.svh
// Assertion macros shared by the key/value slot table RTL.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked every clock, disabled while reset is high.
`define KV_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// Next-cycle implication, disabled while reset is high.
`define KV_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`endif

FILE: hdl/kvst_pkg.sv
// Types, codes and constants of the key/value slot table.
// No dependencies.
package kvst_pkg;
   localparam int SLOTS = 64;
   localparam int SLOT_W = $clog2(SLOTS);
   localparam int CNT_W = $clog2(SLOTS + 1);
   localparam logic [30:0] SERIAL_MAX = 31'h7FFF_FFFF;
   localparam logic [30:0] SERIAL_ONE = 31'd1;

   typedef enum logic [2:0] {
      FN_CREATE = 3'd0, FN_READ = 3'd1, FN_READ_ALL = 3'd2,
      FN_CHANGE = 3'd3, FN_DELETE = 3'd4, FN_DELETE_ALL = 3'd5
   } func_type;

   typedef enum logic [2:0] {
      ST_OK = 3'd0, ST_INVALID = 3'd1, ST_EXISTS = 3'd2, ST_FULL = 3'd3,
      ST_NOT_FOUND = 3'd4, ST_MISMATCH = 3'd5, ST_EMPTY = 3'd6
   } status_type;

   typedef enum logic [2:0] {
      S_CLEAR, S_IDLE, S_SCAN, S_DECIDE, S_DUMP, S_RESP
   } state_type;

   typedef struct packed {
      logic [30:0] serial;
      logic [63:0] key;
      logic [63:0] value;
   } entry_type;
endpackage

FILE: hdl/kvst_ram.sv
// Single-port-write, one-read synchronous RAM for table entries.
// Depends on kvst_pkg.
module kvst_ram (
   input  logic                             clock,
   input  logic                             wr_en,
   input  logic [kvst_pkg::SLOT_W-1:0]      wr_addr,
   input  kvst_pkg::entry_type              wr_data,
   input  logic [kvst_pkg::SLOT_W-1:0]      rd_addr,
   output kvst_pkg::entry_type              rd_data
);
   kvst_pkg::entry_type mem [kvst_pkg::SLOTS];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

FILE: hdl/key_value_slot_table_top.sv
// Top level of the key/value slot table: command sequencer around the entry RAM.
// Depends on kvst_pkg, kvst_ram and assert_macros.svh.
`include "assert_macros.svh"
// Key/value slot table. One command is taken at a time on the req_ stream; its results
// leave on rsp_. Every lookup scans all SLOTS entries of the RAM one per cycle; a
// single-result command goes from idle through the scan and a deciding step to its
// result, which is held until rsp_tready takes it. Read all emits one item per occupied
// slot, or one empty item when no slot is occupied, and stalls its scan while a result
// waits. Delete all and reset run a clearing pass over the RAM during which req_tready
// stays low. Free slots hold serial zero.
module key_value_slot_table_top (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [199:0] req_tdata,   // func[2:0], key[66:3], value[130:67], new_value[194:131]
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [167:0] rsp_tdata,   // status[2:0], serial[33:3], key_out[97:34], value_out[161:98]
   output logic         rsp_tlast
);
   localparam int SW = kvst_pkg::SLOT_W;
   localparam int CW = kvst_pkg::CNT_W;

   kvst_pkg::state_type state_ff, state_in;
   logic [2:0]   func_ff, func_in;
   logic [63:0]  key_ff, key_in, val_ff, val_in, nval_ff, nval_in;
   logic [CW-1:0] cnt_ff, cnt_in;       // scan position
   logic [CW-1:0] used_ff, used_in;     // occupied slots
   logic [30:0]  next_ff, next_in;
   logic         hit_ff, hit_in, free_ok_ff, free_ok_in;
   logic [SW-1:0] hit_idx_ff, hit_idx_in, free_idx_ff, free_idx_in;
   kvst_pkg::entry_type hit_ent_ff, hit_ent_in;
   logic         pend_ff, pend_in;      // read data of previous address is valid
   logic [SW-1:0] pend_idx_ff, pend_idx_in;
   logic         any_ff, any_in;        // read all emitted something
   logic [2:0]   ost_ff, ost_in;
   logic [30:0]  oser_ff, oser_in;
   logic [63:0]  okey_ff, okey_in, oval_ff, oval_in;
   logic         olast_ff, olast_in, ovalid_ff, ovalid_in;
   logic         dump_hold;             // dump entry waits for the output register

   logic         wr_en;
   logic [SW-1:0] wr_addr, rd_addr;
   kvst_pkg::entry_type wr_data, rd_data;

   kvst_ram u_ram (.clock, .wr_en, .wr_addr, .wr_data, .rd_addr, .rd_data);

   assign req_tready = (state_ff == kvst_pkg::S_IDLE);
   assign rsp_tvalid = ovalid_ff;
   assign rsp_tlast  = olast_ff;
   assign rsp_tdata  = {6'd0, oval_ff, okey_ff, oser_ff, ost_ff};
   // while a dump entry is held, read its slot again so the data stays in place
   assign dump_hold  = (state_ff == kvst_pkg::S_DUMP) && pend_ff && rd_data.serial != '0 &&
                       ovalid_ff && !rsp_tready;
   assign rd_addr    = dump_hold ? pend_idx_ff : cnt_ff[SW-1:0];

   logic scan_end;
   assign scan_end = (cnt_ff == CW'(kvst_pkg::SLOTS));

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         kvst_pkg::S_CLEAR: if (scan_end) state_in = kvst_pkg::S_IDLE;
         kvst_pkg::S_IDLE: begin
            if (req_tvalid) begin
               case (req_tdata[2:0])
                  kvst_pkg::FN_READ_ALL: state_in = kvst_pkg::S_DUMP;
                  kvst_pkg::FN_DELETE_ALL: state_in = kvst_pkg::S_RESP;
                  kvst_pkg::FN_CREATE, kvst_pkg::FN_READ, kvst_pkg::FN_CHANGE,
                  kvst_pkg::FN_DELETE: state_in = kvst_pkg::S_SCAN;
                  default: state_in = kvst_pkg::S_RESP;
               endcase
            end
         end
         kvst_pkg::S_SCAN: if (scan_end && !pend_ff) state_in = kvst_pkg::S_DECIDE;
         kvst_pkg::S_DECIDE: state_in = kvst_pkg::S_RESP;
         kvst_pkg::S_DUMP: begin
            // entries emitted and the last one taken: done; nothing emitted: empty item
            if (scan_end && !pend_ff && !ovalid_ff)
               state_in = any_ff ? kvst_pkg::S_IDLE : kvst_pkg::S_RESP;
         end
         kvst_pkg::S_RESP: begin
            if (ovalid_ff && rsp_tready)
               state_in = (func_ff == kvst_pkg::FN_DELETE_ALL) ? kvst_pkg::S_CLEAR
                                                               : kvst_pkg::S_IDLE;
         end
         default: state_in = kvst_pkg::S_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      func_in = func_ff; key_in = key_ff; val_in = val_ff; nval_in = nval_ff;
      cnt_in = cnt_ff; used_in = used_ff; next_in = next_ff;
      hit_in = hit_ff; hit_idx_in = hit_idx_ff; hit_ent_in = hit_ent_ff;
      free_ok_in = free_ok_ff; free_idx_in = free_idx_ff;
      pend_in = 1'b0; pend_idx_in = pend_idx_ff; any_in = any_ff;
      ost_in = ost_ff; oser_in = oser_ff; okey_in = okey_ff; oval_in = oval_ff;
      olast_in = olast_ff; ovalid_in = ovalid_ff;
      wr_en = 1'b0; wr_addr = cnt_ff[SW-1:0]; wr_data = '0;
      if (ovalid_ff && rsp_tready) ovalid_in = 1'b0;
      unique case (state_ff)
         kvst_pkg::S_CLEAR: begin
            wr_en = !scan_end;
            cnt_in = scan_end ? '0 : cnt_ff + 1'b1;
            used_in = '0; next_in = kvst_pkg::SERIAL_ONE;
         end
         kvst_pkg::S_IDLE: begin
            func_in = req_tdata[2:0]; key_in = req_tdata[66:3];
            val_in = req_tdata[130:67]; nval_in = req_tdata[194:131];
            cnt_in = '0; hit_in = 1'b0; free_ok_in = 1'b0; any_in = 1'b0;
            ost_in = kvst_pkg::ST_INVALID; oser_in = '0; okey_in = '0; oval_in = '0;
            olast_in = 1'b1;
            if (req_tvalid && req_tdata[2:0] == kvst_pkg::FN_DELETE_ALL)
               ost_in = kvst_pkg::ST_OK;
            if (req_tvalid && (req_tdata[2:0] == kvst_pkg::FN_DELETE_ALL ||
                               req_tdata[2:0] > kvst_pkg::FN_DELETE_ALL))
               ovalid_in = 1'b1;
         end
         kvst_pkg::S_SCAN: begin
            if (pend_ff) begin
               if (rd_data.serial != '0 && rd_data.key == key_ff && !hit_ff) begin
                  hit_in = 1'b1; hit_idx_in = pend_idx_ff; hit_ent_in = rd_data;
               end
               if (rd_data.serial == '0 && !free_ok_ff) begin
                  free_ok_in = 1'b1; free_idx_in = pend_idx_ff;
               end
            end
            if (!scan_end) begin
               pend_in = 1'b1; pend_idx_in = cnt_ff[SW-1:0]; cnt_in = cnt_ff + 1'b1;
            end
         end
         kvst_pkg::S_DUMP: begin
            // issue a read only when the output register can take its data
            if (dump_hold) begin
               pend_in = 1'b1;
            end else begin
               if (pend_ff && rd_data.serial != '0) begin
                  ovalid_in = 1'b1; any_in = 1'b1; ost_in = kvst_pkg::ST_OK;
                  oser_in = rd_data.serial; okey_in = rd_data.key; oval_in = rd_data.value;
                  olast_in = (used_ff == CW'(1)) ? 1'b1 : 1'b0;
                  used_in = used_ff - 1'b1;
               end
               if (!scan_end) begin
                  pend_in = 1'b1; pend_idx_in = cnt_ff[SW-1:0]; cnt_in = cnt_ff + 1'b1;
               end
            end
            if (state_in == kvst_pkg::S_RESP) begin
               used_in = used_ff;
               ovalid_in = !any_ff; ost_in = kvst_pkg::ST_EMPTY; oser_in = '0;
               okey_in = '0; oval_in = '0; olast_in = 1'b1;
            end
         end
         kvst_pkg::S_DECIDE: begin
            ovalid_in = 1'b1; olast_in = 1'b1; oser_in = '0; okey_in = '0; oval_in = '0;
            case (func_ff)
               kvst_pkg::FN_CREATE: begin
                  if (key_ff == '0 || val_ff == '0) ost_in = kvst_pkg::ST_INVALID;
                  else if (hit_ff) ost_in = kvst_pkg::ST_EXISTS;
                  else if (!free_ok_ff) ost_in = kvst_pkg::ST_FULL;
                  else begin
                     ost_in = kvst_pkg::ST_OK; oser_in = next_ff;
                     wr_en = 1'b1; wr_addr = free_idx_ff;
                     wr_data = '{serial: next_ff, key: key_ff, value: val_ff};
                     used_in = used_ff + 1'b1;
                     if (next_ff != kvst_pkg::SERIAL_MAX) next_in = next_ff + 1'b1;
                  end
               end
               kvst_pkg::FN_READ: begin
                  if (key_ff == '0) ost_in = kvst_pkg::ST_INVALID;
                  else if (!hit_ff) ost_in = kvst_pkg::ST_NOT_FOUND;
                  else begin
                     ost_in = kvst_pkg::ST_OK; oser_in = hit_ent_ff.serial;
                     okey_in = hit_ent_ff.key; oval_in = hit_ent_ff.value;
                  end
               end
               kvst_pkg::FN_CHANGE: begin
                  if (key_ff == '0 || val_ff == '0 || nval_ff == '0)
                     ost_in = kvst_pkg::ST_INVALID;
                  else if (!hit_ff) ost_in = kvst_pkg::ST_NOT_FOUND;
                  else if (hit_ent_ff.value != val_ff) ost_in = kvst_pkg::ST_MISMATCH;
                  else begin
                     ost_in = kvst_pkg::ST_OK; oser_in = hit_ent_ff.serial;
                     wr_en = 1'b1; wr_addr = hit_idx_ff;
                     wr_data = '{serial: hit_ent_ff.serial, key: key_ff, value: nval_ff};
                  end
               end
               default: begin // delete
                  if (key_ff == '0) ost_in = kvst_pkg::ST_INVALID;
                  else if (!hit_ff) ost_in = kvst_pkg::ST_NOT_FOUND;
                  else begin
                     ost_in = kvst_pkg::ST_OK;
                     wr_en = 1'b1; wr_addr = hit_idx_ff; wr_data = '0;
                     used_in = used_ff - 1'b1;
                     if (used_ff == CW'(1)) next_in = kvst_pkg::SERIAL_ONE;
                  end
               end
            endcase
         end
         kvst_pkg::S_RESP: cnt_in = '0;
         default: ;
      endcase
   end

   // read all consumes used_ff as a countdown; restore from a shadow
   logic [CW-1:0] used_save_ff;
   logic [CW-1:0] used_fix;
   assign used_fix = (state_ff == kvst_pkg::S_DUMP && state_in != kvst_pkg::S_DUMP)
                     ? used_save_ff : used_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= kvst_pkg::S_CLEAR;
         cnt_ff <= '0; used_ff <= '0; next_ff <= kvst_pkg::SERIAL_ONE;
         pend_ff <= 1'b0; ovalid_ff <= 1'b0; used_save_ff <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff <= cnt_in; used_ff <= used_fix; next_ff <= next_in;
         pend_ff <= pend_in; ovalid_ff <= ovalid_in;
         if (state_ff == kvst_pkg::S_IDLE) used_save_ff <= used_ff;
      end
      func_ff <= func_in; key_ff <= key_in; val_ff <= val_in; nval_ff <= nval_in;
      hit_ff <= hit_in; hit_idx_ff <= hit_idx_in; hit_ent_ff <= hit_ent_in;
      free_ok_ff <= free_ok_in; free_idx_ff <= free_idx_in;
      pend_idx_ff <= pend_idx_in; any_ff <= any_in;
      ost_ff <= ost_in; oser_ff <= oser_in; okey_ff <= okey_in; oval_ff <= oval_in;
      olast_ff <= olast_in;
   end

   `KV_ASSERT_IMP(a_no_req_busy, clock, reset, state_ff != kvst_pkg::S_IDLE, !req_tready)
   `KV_ASSERT_IMP(a_used_range, clock, reset, 1'b1, used_ff <= CW'(kvst_pkg::SLOTS))
   `KV_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready,
                   rsp_tvalid && $stable(rsp_tdata))
endmodule

FILE: bench/key_value_slot_table_checker.sv
// Checker for the key/value slot table: watches req_ and rsp_, predicts results
// from its own copy of the table, compares field by field. Depends on kvst_pkg.
`timescale 1ns / 100ps
module key_value_slot_table_checker (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   input  logic         req_tready,
   input  logic [199:0] req_tdata,
   input  logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  logic [167:0] rsp_tdata,
   input  logic         rsp_tlast,
   output int           fail_count,
   output int           pending_count
);
   typedef struct {
      kvst_pkg::status_type status;
      logic [30:0] serial;
      logic [63:0] key;
      logic [63:0] value;
      logic        last;
   } reply_type;

   kvst_pkg::entry_type table_mem [kvst_pkg::SLOTS];
   logic [30:0] serial_next;
   reply_type   replies_due [$];

   function automatic int find_key(logic [63:0] k);
      for (int i = 0; i < kvst_pkg::SLOTS; i++)
         if (table_mem[i].serial != 0 && table_mem[i].key == k) return i;
      return -1;
   endfunction

   function automatic void queue_reply(kvst_pkg::status_type st, logic [30:0] ser = 0,
                                       logic [63:0] k = 0, logic [63:0] v = 0,
                                       logic lst = 1'b1);
      reply_type r;
      r.status = st; r.serial = ser; r.key = k; r.value = v; r.last = lst;
      replies_due.push_back(r);
   endfunction

   function automatic void clear_table();
      for (int i = 0; i < kvst_pkg::SLOTS; i++) table_mem[i] = '0;
      serial_next = kvst_pkg::SERIAL_ONE;
   endfunction

   // apply one command to the predicted table
   function automatic void apply_command(logic [199:0] d);
      logic [2:0]  fn;
      logic [63:0] k, v, nv;
      int          idx, n;
      bit          any;
      fn = d[2:0]; k = d[66:3]; v = d[130:67]; nv = d[194:131];
      case (fn)
         kvst_pkg::FN_CREATE: begin
            if (k == 0 || v == 0) queue_reply(kvst_pkg::ST_INVALID);
            else if (find_key(k) >= 0) queue_reply(kvst_pkg::ST_EXISTS);
            else begin
               idx = -1;
               for (int i = kvst_pkg::SLOTS - 1; i >= 0; i--)
                  if (table_mem[i].serial == 0) idx = i;
               if (idx < 0) queue_reply(kvst_pkg::ST_FULL);
               else begin
                  table_mem[idx] = '{serial: serial_next, key: k, value: v};
                  if (serial_next < kvst_pkg::SERIAL_MAX) serial_next++;
                  queue_reply(kvst_pkg::ST_OK, table_mem[idx].serial);
               end
            end
         end
         kvst_pkg::FN_READ: begin
            idx = find_key(k);
            if (k == 0) queue_reply(kvst_pkg::ST_INVALID);
            else if (idx < 0) queue_reply(kvst_pkg::ST_NOT_FOUND);
            else queue_reply(kvst_pkg::ST_OK, table_mem[idx].serial, table_mem[idx].key,
                             table_mem[idx].value);
         end
         kvst_pkg::FN_READ_ALL: begin
            n = 0;
            for (int i = 0; i < kvst_pkg::SLOTS; i++)
               if (table_mem[i].serial != 0) begin
                  queue_reply(kvst_pkg::ST_OK, table_mem[i].serial, table_mem[i].key,
                              table_mem[i].value, 1'b0);
                  n++;
               end
            if (n == 0) queue_reply(kvst_pkg::ST_EMPTY);
            else replies_due[$].last = 1'b1;
         end
         kvst_pkg::FN_CHANGE: begin
            idx = find_key(k);
            if (k == 0 || v == 0 || nv == 0) queue_reply(kvst_pkg::ST_INVALID);
            else if (idx < 0) queue_reply(kvst_pkg::ST_NOT_FOUND);
            else if (table_mem[idx].value != v) queue_reply(kvst_pkg::ST_MISMATCH);
            else begin
               table_mem[idx].value = nv;
               queue_reply(kvst_pkg::ST_OK, table_mem[idx].serial);
            end
         end
         kvst_pkg::FN_DELETE: begin
            idx = find_key(k);
            if (k == 0) queue_reply(kvst_pkg::ST_INVALID);
            else if (idx < 0) queue_reply(kvst_pkg::ST_NOT_FOUND);
            else begin
               table_mem[idx] = '0;
               any = 0;
               for (int i = 0; i < kvst_pkg::SLOTS; i++)
                  if (table_mem[i].serial != 0) any = 1;
               if (!any) serial_next = kvst_pkg::SERIAL_ONE;
               queue_reply(kvst_pkg::ST_OK);
            end
         end
         kvst_pkg::FN_DELETE_ALL: begin
            clear_table();
            queue_reply(kvst_pkg::ST_OK);
         end
         default: queue_reply(kvst_pkg::ST_INVALID);
      endcase
   endfunction

   always @(posedge clock) begin
      reply_type r;
      if (reset) begin
         clear_table();
         replies_due.delete();
         fail_count <= 0;
         pending_count <= 0;
      end else begin
         if (req_tvalid && req_tready) apply_command(req_tdata);
         if (rsp_tvalid && rsp_tready) begin
            if (replies_due.size() == 0) begin
               fail_count <= fail_count + 1;
               if (fail_count < 10) $display("unexpected result item %h", rsp_tdata);
            end else begin
               r = replies_due.pop_front();
               if (rsp_tdata[2:0] !== r.status || rsp_tdata[33:3] !== r.serial ||
                   rsp_tdata[97:34] !== r.key || rsp_tdata[161:98] !== r.value ||
                   rsp_tdata[167:162] !== '0 || rsp_tlast !== r.last) begin
                  fail_count <= fail_count + 1;
                  if (fail_count < 10) begin
                     $display("mismatch: expected st=%0d ser=%0d k=%h v=%h l=%b",
                        r.status, r.serial, r.key, r.value, r.last);
                     $display("          actual   st=%0d ser=%0d k=%h v=%h l=%b",
                        rsp_tdata[2:0], rsp_tdata[33:3], rsp_tdata[97:34],
                        rsp_tdata[161:98], rsp_tlast);
                  end
               end
            end
         end
         pending_count <= replies_due.size();
      end
   end
endmodule

FILE: bench/key_value_slot_table_top_tb.sv
// Testbench top for the key/value slot table: clock, reset, stimulus, verdict.
// Depends on kvst_pkg, key_value_slot_table_top and key_value_slot_table_checker.
`timescale 1ns / 100ps
module key_value_slot_table_top_tb;
   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [199:0] req_tdata = '0;   // func, key, value, new_value from bit 0 up
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [167:0] rsp_tdata;        // status, serial, key_out, value_out from bit 0 up
   logic         rsp_tlast;
   int           fail_count, pending_count;
   int           cycle_count = 0;
   bit           quiet = 0;        // no idling in the final stretch
   bit           hold_rsp = 0;     // long receiver hold-off
   logic [63:0]  key_pool [8];     // small pool so lookups hit often

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   key_value_slot_table_top dut (.*);

   key_value_slot_table_checker checker_i (.*);

   // cycle limit: ~200 items, worst case each a 64-item dump with the longest receiver stalls
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > 2000000) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   // receiver: random stall bursts, one long hold-off on request
   initial begin
      int n;
      @(posedge clock);
      forever begin
         if (hold_rsp) begin
            rsp_tready <= 1'b0;
            @(posedge clock);
         end else if (!quiet && $urandom_range(0, 3) == 0) begin
            n = $urandom_range(1, 16);
            rsp_tready <= 1'b0;
            repeat (n) @(posedge clock);
         end else begin
            rsp_tready <= 1'b1;
            repeat ($urandom_range(1, 20)) @(posedge clock);
         end
      end
   end

   function automatic logic [63:0] rand64();
      return {$urandom(), $urandom()};
   endfunction

   // one item; sender gaps come in bursts before it
   task automatic send(logic [2:0] fn, logic [63:0] k, logic [63:0] v, logic [63:0] nv);
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {5'b0, nv, v, k, fn};
      // req_tready is settled at the falling edge; the next rising edge takes the item
      do @(negedge clock); while (!req_tready);
      @(posedge clock);
   endtask

   function automatic logic [63:0] pick_key();
      return ($urandom_range(0, 9) == 0) ? rand64() : key_pool[$urandom_range(0, 7)];
   endfunction

   initial begin
      logic [63:0] k, v;
      int sel;
      for (int i = 0; i < 8; i++) key_pool[i] = rand64() | 64'h1;
      key_pool[0] = '1;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed: argument checks, extremes, every command and error status
      send(kvst_pkg::FN_READ_ALL, 0, 0, 0);                  // empty table
      send(kvst_pkg::FN_CREATE, 0, 5, 0);                    // missing key
      send(kvst_pkg::FN_CREATE, 7, 0, 0);                    // missing value
      send(kvst_pkg::FN_CREATE, '1, '1, 0);
      send(kvst_pkg::FN_CREATE, '1, 3, 0);                   // duplicate key
      send(kvst_pkg::FN_CREATE, 64'h1, 64'h1, '1);
      send(kvst_pkg::FN_READ, '1, 0, 0);
      send(kvst_pkg::FN_READ, 0, 0, 0);
      send(kvst_pkg::FN_READ, 64'h2, 0, 0);                  // unknown key
      send(kvst_pkg::FN_CHANGE, 64'h1, 64'h1, 0);            // missing new value
      send(kvst_pkg::FN_CHANGE, 64'h1, 64'h9, 64'h5);        // old value mismatch
      send(kvst_pkg::FN_CHANGE, 64'h3, 64'h1, 64'h5);        // unknown key
      send(kvst_pkg::FN_CHANGE, 64'h1, 64'h1, '1);
      send(kvst_pkg::FN_READ_ALL, 0, 0, 0);
      send(3'd6, 1, 1, 1);                                   // unknown commands
      send(3'd7, '1, '1, '1);
      send(kvst_pkg::FN_DELETE, 0, 0, 0);
      send(kvst_pkg::FN_DELETE, 64'h5, 0, 0);
      send(kvst_pkg::FN_DELETE, 64'h1, 0, 0);
      send(kvst_pkg::FN_DELETE, '1, 0, 0);                   // last entry: counter back to one
      send(kvst_pkg::FN_CREATE, 64'h42, 64'h42, 0);
      send(kvst_pkg::FN_DELETE_ALL, 0, 0, 0);
      // fill the table past full, with the receiver held off at first
      hold_rsp = 1;
      fork
         begin
            repeat (400) @(posedge clock);
            hold_rsp = 0;
         end
      join_none
      for (int i = 0; i < kvst_pkg::SLOTS + 2; i++)
         send(kvst_pkg::FN_CREATE, rand64() | 64'h100, rand64(), 0);
      send(kvst_pkg::FN_READ_ALL, 0, 0, 0);
      send(kvst_pkg::FN_DELETE_ALL, 0, 0, 0);

      // random: mostly well-formed commands on a small key pool
      for (int i = 0; i < 110; i++) begin
         if (i == 90) quiet = 1;
         sel = $urandom_range(0, 99);
         k = pick_key();
         v = ($urandom_range(0, 1)) ? 64'($urandom_range(1, 3)) : rand64();
         if (sel < 30)      send(kvst_pkg::FN_CREATE, k, v, 0);
         else if (sel < 45) send(kvst_pkg::FN_READ, k, 0, 0);
         else if (sel < 52) send(kvst_pkg::FN_READ_ALL, 0, 0, 0);
         else if (sel < 70) send(kvst_pkg::FN_CHANGE, k, v, 64'($urandom_range(1, 3)));
         else if (sel < 85) send(kvst_pkg::FN_DELETE, k, 0, 0);
         else if (sel < 88) send(kvst_pkg::FN_DELETE_ALL, 0, 0, 0);
         else if (sel < 94) send(3'($urandom_range(0, 7)),
                                 ($urandom_range(0, 1)) ? 64'h0 : k,
                                 ($urandom_range(0, 1)) ? 64'h0 : v,
                                 ($urandom_range(0, 1)) ? 64'h0 : rand64());
         else send(3'($urandom_range(0, 7)), rand64(), rand64(), rand64());
      end
      req_tvalid <= 1'b0;

      @(negedge clock);
      while (pending_count != 0) @(negedge clock);
      repeat (200) @(posedge clock);
      if (fail_count == 0) $display("Test completed successfully");
      else $display("Test completed with failures");
      $finish;
   end
endmodule

FILE: filelist.f
+incdir+hdl
hdl/kvst_pkg.sv
hdl/kvst_ram.sv
hdl/key_value_slot_table_top.sv
bench/key_value_slot_table_checker.sv
bench/key_value_slot_table_top_tb.sv
